// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque core
// Operation and status codes, plus the control word that rides along the
// cell chain with each request.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    K_PUSH_FRONT = 2'd0,
    K_PUSH_REAR  = 2'd1,
    K_POP_FRONT  = 2'd2,
    K_POP_REAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control word carried from cell to cell with each request.
  typedef struct packed {
    logic    valid;
    logic    wr;
    logic    rd;
    status_t status;
  } ctl_t;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl: pointer and status control
// Holds head, tail, empty flag and capacity; turns each request into a
// store access (slot, write or read) and a status for the cell chain.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     take,
  input  kind_t                    kind,
  input  logic [DATA_W-1:0]        value,
  output ctl_t                     req_ctl,
  output logic [$clog2(DEPTH)-1:0] req_slot,
  output logic [DATA_W-1:0]        req_data
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [31:0] DEPTH_U = 32'(DEPTH);

  logic [CAP_W-1:0] capacity;
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic             empty;
  logic [IW-1:0]    head_next;
  logic [IW-1:0]    tail_next;
  logic             empty_next;
  logic [IW-1:0]    capm1;
  logic [IW-1:0]    head_up;
  logic [IW-1:0]    head_dn;
  logic [IW-1:0]    tail_up;
  logic [IW-1:0]    tail_dn;
  logic             full;

  // Last usable index: zero acts as one entry, oversize clamps to the depth.
  always_comb begin
    if (capacity == '0) begin
      capm1 = '0;
    end else if (32'(capacity) > DEPTH_U) begin
      capm1 = IW'(DEPTH - 1);
    end else begin
      capm1 = IW'(capacity - CAP_W'(1));
    end
  end

  assign head_up = (head >= capm1) ? '0 : head + IW'(1);
  assign tail_up = (tail >= capm1) ? '0 : tail + IW'(1);
  assign head_dn = (head == '0) ? capm1 : head - IW'(1);
  assign tail_dn = (tail == '0) ? capm1 : tail - IW'(1);

  // Full when head sits one past tail, directly or by wrap (tail at capm1, head at zero).
  assign full = !empty &&
                ((head == '0 && tail == capm1) ||
                 ({1'b0, head} == ({1'b0, tail} + (IW+1)'(1))));

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    empty_next     = empty;
    req_ctl.valid  = take;
    req_ctl.wr     = 1'b0;
    req_ctl.rd     = 1'b0;
    req_ctl.status = ST_DONE;
    req_slot       = '0;
    req_data       = '0;
    unique case (kind)
      K_PUSH_FRONT, K_PUSH_REAR: begin
        req_data = value;
        if (full) begin
          req_ctl.status = ST_OVERFLOW;
        end else begin
          req_ctl.wr = 1'b1;
          if (empty) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b0;
            req_slot   = '0;
          end else if (kind == K_PUSH_FRONT) begin
            head_next = head_dn;
            req_slot  = head_dn;
          end else begin
            tail_next = tail_up;
            req_slot  = tail_up;
          end
        end
      end
      K_POP_FRONT, K_POP_REAR: begin
        if (empty) begin
          req_ctl.status = ST_UNDERFLOW;
        end else begin
          req_ctl.rd = 1'b1;
          req_slot   = (kind == K_POP_FRONT) ? head : tail;
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (kind == K_POP_FRONT) begin
            head_next = head_up;
          end else begin
            tail_next = tail_dn;
          end
        end
      end
      default: begin
        req_ctl.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (take) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
    end
  end

  a_empty_parks: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0 && tail == '0))
    else $error("empty deque with pointers away from zero");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (take && req_ctl.wr) |=> !empty)
    else $error("deque still empty after a push");

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(req_ctl.wr && req_ctl.rd))
    else $error("request both reads and writes the store");

  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    (take && req_ctl.rd && head == tail) |=> empty)
    else $error("popping the last entry left deque non-empty");

endmodule

// ===== rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one cell of the store chain
// Owns one interleaved bank of the store; performs the access of a passing
// request on a slot it owns and hands the request to the next cell.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int DEPTH   = 256,
  parameter int CELLS   = 4,
  parameter int CELL_ID = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  ctl_t                     in_ctl,
  input  logic [$clog2(DEPTH)-1:0] in_slot,
  input  logic [DATA_W-1:0]        in_data,
  output ctl_t                     out_ctl,
  output logic [$clog2(DEPTH)-1:0] out_slot,
  output logic [DATA_W-1:0]        out_data
);

  localparam int unsigned IW     = $clog2(DEPTH);
  localparam int unsigned CB     = $clog2(CELLS);
  localparam int unsigned LDEPTH = (DEPTH + CELLS - 1) / CELLS;
  localparam int unsigned LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

  logic [DATA_W-1:0] mem [LDEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] data_q;
  logic              hit_q;
  logic [IW-1:0]     slot_sh;
  logic [LAW-1:0]    laddr;
  logic              owned;
  logic              access;

  assign slot_sh = in_slot >> CB;
  assign laddr   = slot_sh[LAW-1:0];
  assign owned   = (in_slot[CB-1:0] == CB'(CELL_ID));
  assign access  = adv && in_ctl.valid && owned;

  always_ff @(posedge clk) begin
    if (access) begin
      if (in_ctl.wr) begin
        mem[laddr] <= in_data;
      end
      if (in_ctl.rd) begin
        mem_q <= mem[laddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
      hit_q   <= 1'b0;
    end else if (adv) begin
      out_ctl <= in_ctl;
      hit_q   <= in_ctl.valid && in_ctl.rd && owned;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slot <= in_slot;
      data_q   <= in_data;
    end
  end

  // Substitute the bank read for the carried data on a hit.
  assign out_data = hit_q ? mem_q : data_q;

endmodule

// ===== rtl/circular_deque_core.sv =====
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue in a circular store
// Path: an accepted request passes the CELLS cell registers to m_tvalid.
// Throughput: one request per cycle while no result stalls; the store access
//   of each request moves one cell per cycle down a chain of CELLS banks.
// A result not taken holds the whole chain and s_tready drops with it.
// Reset: head, tail at zero, deque empty, capacity 256; store not cleared.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 256,  // built store depth, 2..65536
  parameter int CELLS = 4     // banks in the chain, power of two, 2..DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // capacity register
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  // request channel
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [DATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic [1:0]         s_tuser,   // [1:0] kind
  // result channel
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [DATA_W-1:0]  m_tdata,   // [31:0] popped
  output logic [1:0]         m_tuser    // [1:0] status
);

  localparam int unsigned IW = $clog2(DEPTH);

  // Chain links: index 0 comes from the pointer control, CELLS is the tail.
  ctl_t              link_ctl  [CELLS+1];
  logic [IW-1:0]     link_slot [CELLS+1];
  logic [DATA_W-1:0] link_data [CELLS+1];

  logic adv;
  logic take;

  // Advance the chain unless a finished result is waiting downstream.
  assign adv      = !link_ctl[CELLS].valid || m_tready;
  assign s_tready = adv;
  assign take     = s_tvalid && adv;

  // Pointer bookkeeping resolves status and slot in the accept cycle.
  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .kind      (kind_t'(s_tuser)),
    .value     (s_tdata),
    .req_ctl   (link_ctl[0]),
    .req_slot  (link_slot[0]),
    .req_data  (link_data[0])
  );

  // Interleaved banks: a slot lives in the cell given by its low bits.
  // Requests keep their order through the chain, so a write always lands
  // before any later read of the same slot reaches that cell.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cdq_cell #(
      .DEPTH   (DEPTH),
      .CELLS   (CELLS),
      .CELL_ID (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (link_ctl[i]),
      .in_slot  (link_slot[i]),
      .in_data  (link_data[i]),
      .out_ctl  (link_ctl[i+1]),
      .out_slot (link_slot[i+1]),
      .out_data (link_data[i+1])
    );
  end

  // Drive the result from the last cell; popped is zero unless a pop hit.
  assign m_tvalid = link_ctl[CELLS].valid;
  assign m_tuser  = link_ctl[CELLS].status;
  assign m_tdata  = link_ctl[CELLS].rd ? link_data[CELLS] : '0;

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request accepted while result stalled");

  a_enter_chain: assert property (@(posedge clk) disable iff (rst)
    take |=> link_ctl[1].valid)
    else $error("accepted request missing from first cell");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && link_ctl[CELLS].rd) |-> (m_tuser == ST_DONE))
    else $error("read result carries a failure status");

endmodule
